@@ hdl/noise_dose_accumulator_core_assert.svh @@
// Assertion macros shared by the noise dose accumulator RTL.
`ifndef NOISE_DOSE_ACCUMULATOR_CORE_ASSERT_SVH
`define NOISE_DOSE_ACCUMULATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/nda_pkg.sv @@
// Package with widths, constants, tables and helper types of the noise dose accumulator.
package nda_pkg;

	// Store and table sizing.
	localparam int ACCUM_WIDTH     = 48;
	localparam int EXP_TABLE_DEPTH = 64;

	// Field widths.
	localparam int LVL_W  = 16;
	localparam int DUR_W  = 16;
	localparam int Q_W    = 14;
	localparam int CT_W   = 25;
	localparam int PCT_W  = 32;
	localparam int TIME_W = 40;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Exponent path widths.
	localparam int DIFF_W = LVL_W + 1;
	localparam int EMAG_W = 36;
	localparam int EXPN_W = EMAG_W + 1;
	localparam int SH_W   = EXPN_W - 16 + 1;
	localparam int TAB_W  = 18;
	localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
	localparam int TIX_W  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int P_W    = 16 + IDX_W;
	localparam int PROD_W = DUR_W + TAB_W;
	localparam int SHL_W  = PROD_W + ACCUM_WIDTH;
	localparam int SHA_W  = $clog2(ACCUM_WIDTH);
	localparam int SHR_W  = $clog2(PROD_W);

	// Divider widths.
	localparam int NUM_W     = ACCUM_WIDTH + 7;
	localparam int DEN_W     = TIME_W;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	// Logarithm and TWA widths.
	localparam int LOG_W = 21;
	localparam int LG_W  = LOG_W + 1;
	localparam int T1_W  = LG_W + Q_W + 1;
	localparam int T2_W  = T1_W + 16;

	// Fixed-point constants.
	localparam int          LOG2_10_Q16 = 217706;
	localparam logic [18:0] EXP_SCALE   = 19'(2 * LOG2_10_Q16);
	localparam logic [14:0] LOG10_2_Q16 = 15'd19728;

	localparam logic [ACCUM_WIDTH-1:0] ACC_MAX  = '1;
	localparam logic [TIME_W-1:0]      TIME_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_CRITERION = 2'd1;
	localparam logic [1:0] REG_EXCHANGE  = 2'd2;
	localparam logic [1:0] REG_CRIT_TIME = 2'd3;

	// Register reset values.
	localparam logic [LVL_W-1:0] THRESHOLD_RST = 16'd10240;
	localparam logic [LVL_W-1:0] CRITERION_RST = 16'd10880;
	localparam logic [Q_W-1:0]   EXCHANGE_RST  = 14'd2551;
	localparam logic [CT_W-1:0]  CRIT_TIME_RST = 25'd28800000;

	typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

	// Status returned by the shared divider.
	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

	// Integer square root, used only while building the table.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(k/D) in Q16, as a product of 2^(2^-i) factors in Q30.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		logic [63:0] c [1:16];
		logic [63:0] x;
		logic [63:0] v;
		int          i;
		int          k;
		c[1] = isqrt64(64'd1 << 61);
		for (i = 2; i <= 16; i++) c[i] = isqrt64(c[i-1] << 30);
		for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
			x = (64'(k) << 16) / EXP_TABLE_DEPTH;
			v = 64'd1 << 30;
			for (i = 1; i <= 16; i++) begin
				if (x[16-i]) v = (v * c[i] + (64'd1 << 29)) >> 30;
			end
			t[k] = TAB_W'((v + (64'd1 << 13)) >> 14);
		end
		t[EXP_TABLE_DEPTH] = TAB_W'(131072);
		return t;
	endfunction

	// Base-2 logarithm in Q16 by repeated squaring, for constants only.
	function automatic logic [63:0] log2_q16_const(input logic [63:0] x);
		int          n;
		int          i;
		logic [63:0] y;
		logic [63:0] r;
		n = 63;
		while (n > 0 && !x[n]) n--;
		y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
		r = 64'(n) * 64'd65536;
		for (i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r = r + (64'd1 << i);
			end
		end
		return r;
	endfunction

	localparam exp_tab_t         EXP_TAB    = build_exp_tab();
	localparam logic [LOG_W-1:0] LOG2_25600 = LOG_W'(log2_q16_const(64'd25600));

endpackage

@@ hdl/nda_meas_if.sv @@
// Channel carrying one measured block into the accumulator.
interface nda_meas_if import nda_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic signed [LVL_W-1:0] level;
	logic [DUR_W-1:0]        duration_ms;

	modport source(output valid, mode, level, duration_ms, input ready);
	modport sink(input valid, mode, level, duration_ms, output ready);
endinterface

@@ hdl/nda_report_if.sv @@
// Channel carrying one dose report out of the accumulator.
interface nda_report_if import nda_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [PCT_W-1:0]        dose_percent;
	logic [PCT_W-1:0]        projected_percent;
	logic                    projected_valid;
	logic signed [LVL_W-1:0] twa_level;
	logic                    twa_valid;
	logic [TIME_W-1:0]       below_time_ms;
	logic [TIME_W-1:0]       total_time_ms;

	modport source(output valid, dose_percent, projected_percent, projected_valid,
		twa_level, twa_valid, below_time_ms, total_time_ms, input ready);
	modport sink(input valid, dose_percent, projected_percent, projected_valid,
		twa_level, twa_valid, below_time_ms, total_time_ms, output ready);
endinterface

@@ hdl/nda_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module nda_div import nda_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output div_stat_t        stat
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     n_q;
	logic [DEN_W:0]       r_q;
	logic [DEN_W-1:0]     den_q;

	logic [DEN_W:0] r_sh;
	logic           ge;
	logic [DEN_W:0] r_nxt;

	// One restoring step: bring down the next numerator bit and try a subtract.
	always_comb begin
		r_sh  = {r_q[DEN_W-1:0], n_q[NUM_W-1]};
		ge    = r_sh >= {1'b0, den_q};
		r_nxt = ge ? (r_sh - {1'b0, den_q}) : r_sh;
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The numerator register shifts out dividend bits and shifts in quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (run_q) begin
			n_q <= {n_q[NUM_W-2:0], ge};
			r_q <= r_nxt;
		end
	end

	assign quo         = n_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = |r_q;

endmodule

@@ hdl/nda_log.sv @@
// Serial base-2 logarithm in Q16: normalize one bit a cycle, then one squaring a cycle.
module nda_log import nda_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PCT_W-1:0] x,
	output logic [LOG_W-1:0] lg,
	output logic             done
);

	localparam logic [1:0] LS_IDLE = 2'd0;
	localparam logic [1:0] LS_NORM = 2'd1;
	localparam logic [1:0] LS_SQR  = 2'd2;

	logic [1:0]       state_q;
	logic             done_q;
	logic [3:0]       it_q;
	logic [4:0]       n_q;
	logic [PCT_W-1:0] xn_q;
	logic [30:0]      y_q;
	logic [15:0]      fr_q;

	logic [61:0] sq;
	logic [31:0] ys;

	// Square the Q30 mantissa and drop back to Q30.
	always_comb begin
		sq = 62'(y_q) * 62'(y_q);
		ys = sq[61:30];
	end

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			done_q  <= 1'b0;
			it_q    <= '0;
			n_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				LS_IDLE: begin
					if (start) begin
						n_q     <= 5'd31;
						state_q <= LS_NORM;
					end
				end
				LS_NORM: begin
					if (xn_q[PCT_W-1] || n_q == 5'd0) begin
						it_q    <= 4'd15;
						state_q <= LS_SQR;
					end else begin
						n_q <= n_q - 5'd1;
					end
				end
				LS_SQR: begin
					it_q <= it_q - 4'd1;
					if (it_q == 4'd0) begin
						done_q  <= 1'b1;
						state_q <= LS_IDLE;
					end
				end
				default: state_q <= LS_IDLE;
			endcase
		end
	end

	// Mantissa and fraction shift registers; fraction bits arrive most significant first.
	always_ff @(posedge clk) begin
		if (state_q == LS_IDLE && start) begin
			xn_q <= x;
		end else if (state_q == LS_NORM) begin
			if (xn_q[PCT_W-1] || n_q == 5'd0) begin
				y_q  <= xn_q[PCT_W-1:1];
				fr_q <= '0;
			end else begin
				xn_q <= {xn_q[PCT_W-2:0], 1'b0};
			end
		end else if (state_q == LS_SQR) begin
			fr_q <= {fr_q[14:0], ys[31]};
			y_q  <= ys[31] ? ys[31:1] : ys[30:0];
		end
	end

	assign lg   = {n_q, fr_q};
	assign done = done_q;

endmodule

@@ hdl/noise_dose_accumulator_core.sv @@
// Top level of the noise dose accumulator with its configuration registers.
//
// Usage: each word on the meas channel is one measured block (mode, level in 1/128 dB,
// duration in ms). Mode 1 clears the dose and time stores. Each word accepted yields
// exactly one word on the report channel with dose percent, projected percent, TWA level
// and the two time totals, all taken after that word has been applied.
// One word is worked on at a time. Each divide runs on the shared bit-serial divider;
// a block that adds dose takes three divides, others take two, and a nonzero dose adds
// the serial logarithm. The next word is taken as soon as the report sits in the output
// register.
// Reset: the stores clear to zero and the registers return to their defaults
// (threshold 80 dB, criterion 85 dB, divisor 2551, criterion time eight hours).
// Stall: a finished report waits in the output register; while it is not taken, the
// following word is still accepted and worked on, and its report waits at the end.
// Registers are written over the APB port at byte addresses 0, 4, 8 and 12; pready is high.
`include "noise_dose_accumulator_core_assert.svh"

module noise_dose_accumulator_core import nda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	nda_meas_if.sink          meas,
	nda_report_if.source      report,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_EXP_LD   = 4'd1;
	localparam logic [3:0] S_EXP_DIV  = 4'd2;
	localparam logic [3:0] S_EXP_TAB  = 4'd3;
	localparam logic [3:0] S_EXP_PROD = 4'd4;
	localparam logic [3:0] S_EXP_ADD  = 4'd5;
	localparam logic [3:0] S_DOSE_LD  = 4'd6;
	localparam logic [3:0] S_DOSE_DIV = 4'd7;
	localparam logic [3:0] S_PROJ_LD  = 4'd8;
	localparam logic [3:0] S_PROJ_DIV = 4'd9;
	localparam logic [3:0] S_LOG_LD   = 4'd10;
	localparam logic [3:0] S_LOG_RUN  = 4'd11;
	localparam logic [3:0] S_TWA_M1   = 4'd12;
	localparam logic [3:0] S_TWA_M2   = 4'd13;
	localparam logic [3:0] S_TWA_SUM  = 4'd14;
	localparam logic [3:0] S_FIN      = 4'd15;

	// Saturate a divider quotient to the 32-bit percent range.
	function automatic logic [PCT_W-1:0] sat_pct(input logic [NUM_W-1:0] v);
		return (|v[NUM_W-1:PCT_W]) ? '1 : v[PCT_W-1:0];
	endfunction

	logic [3:0] state_q;

	// Configuration registers.
	logic [LVL_W-1:0] thr_q;
	logic [LVL_W-1:0] crit_q;
	logic [Q_W-1:0]   q_q;
	logic [CT_W-1:0]  ct_q;

	// Stores.
	logic [ACCUM_WIDTH-1:0] acc_q;
	logic [TIME_W-1:0]      tb_q;
	logic [TIME_W-1:0]      tt_q;

	// Working registers of one item.
	logic [DIFF_W-1:0]      d_q;
	logic [DUR_W-1:0]       dur_q;
	logic [EXPN_W-1:0]      e_q;
	logic [TAB_W-1:0]       tbase_q;
	logic [TAB_W-1:0]       tint_q;
	logic [PROD_W-1:0]      prod_q;
	logic [PCT_W-1:0]       dose_q;
	logic [PCT_W-1:0]       proj_q;
	logic signed [LG_W-1:0] lg_q;
	logic signed [T1_W-1:0] t1_q;
	logic signed [T2_W-1:0] t2_q;
	logic [LVL_W-1:0]       twa_q;

	// Output register.
	logic              rpt_valid_q;
	logic [PCT_W-1:0]  rpt_dose_q;
	logic [PCT_W-1:0]  rpt_proj_q;
	logic              rpt_pv_q;
	logic [LVL_W-1:0]  rpt_twa_q;
	logic              rpt_tv_q;
	logic [TIME_W-1:0] rpt_tb_q;
	logic [TIME_W-1:0] rpt_tt_q;

	logic cfg_wr;
	logic accept;
	logic fin_go;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] div_quo;
	div_stat_t        div_stat;

	logic             log_start;
	logic [LOG_W-1:0] log_val;
	logic             log_done;

	// Shared bit-serial divider for the exponent and both percentages.
	nda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// Serial logarithm for the TWA level.
	nda_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (dose_q),
		.lg     (log_val),
		.done   (log_done)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign accept = meas.valid && meas.ready;
	assign fin_go = (state_q == S_FIN) && (!rpt_valid_q || report.ready);

	assign meas.ready = (state_q == S_IDLE);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			crit_q <= CRITERION_RST;
			q_q    <= EXCHANGE_RST;
			ct_q   <= CRIT_TIME_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_THRESHOLD: thr_q  <= pwdata[LVL_W-1:0];
				REG_CRITERION: crit_q <= pwdata[LVL_W-1:0];
				REG_EXCHANGE:  q_q    <= pwdata[Q_W-1:0];
				REG_CRIT_TIME: ct_q   <= pwdata[CT_W-1:0];
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[3:2])
			REG_THRESHOLD: prdata = DATA_W'(thr_q);
			REG_CRITERION: prdata = DATA_W'(crit_q);
			REG_EXCHANGE:  prdata = DATA_W'(q_q);
			REG_CRIT_TIME: prdata = DATA_W'(ct_q);
		endcase
	end

	// Input decode: level against threshold and criterion, saturating time sums.
	logic              below;
	logic [DIFF_W-1:0] d_new;
	logic [TIME_W:0]   tt_sum;
	logic [TIME_W:0]   tb_sum;
	logic [TIME_W-1:0] tt_add;
	logic [TIME_W-1:0] tb_add;

	always_comb begin
		below  = $signed(meas.level) < $signed(thr_q);
		d_new  = {meas.level[LVL_W-1], meas.level} - {crit_q[LVL_W-1], crit_q};
		tt_sum = (TIME_W+1)'(tt_q) + (TIME_W+1)'(meas.duration_ms);
		tb_sum = (TIME_W+1)'(tb_q) + (TIME_W+1)'(meas.duration_ms);
		tt_add = tt_sum[TIME_W] ? TIME_MAX : tt_sum[TIME_W-1:0];
		tb_add = tb_sum[TIME_W] ? TIME_MAX : tb_sum[TIME_W-1:0];
	end

	// Exponent numerator: |2 * d * log2(10)| in Q16.
	logic [DIFF_W-1:0] d_mag;
	logic [EMAG_W-1:0] exp_mag;
	logic [EMAG_W:0]   e_mag;

	always_comb begin
		d_mag   = d_q[DIFF_W-1] ? (-d_q) : d_q;
		exp_mag = EMAG_W'(d_mag) * EMAG_W'(EXP_SCALE);
		e_mag   = (EMAG_W+1)'(div_quo[EMAG_W-1:0])
			+ (EMAG_W+1)'(d_q[DIFF_W-1] & div_stat.rem_nz);
	end

	// Divider operand selection.
	always_comb begin
		div_start = (state_q == S_EXP_LD) || (state_q == S_DOSE_LD) || (state_q == S_PROJ_LD);
		if (state_q == S_EXP_LD) begin
			div_num = NUM_W'(exp_mag);
			div_den = (q_q == '0) ? DEN_W'(1) : DEN_W'(q_q);
		end else begin
			div_num = NUM_W'(acc_q) * NUM_W'(100);
			div_den = (state_q == S_DOSE_LD) ? DEN_W'(ct_q) : tt_q;
		end
	end

	// Table lookup with linear interpolation of the fractional exponent.
	logic [P_W-1:0]        tab_pos;
	logic [TIX_W-1:0]      tix;
	logic [15:0]           tab_w;
	logic [TAB_W-1:0]      tab_lo;
	logic [TAB_W-1:0]      tab_hi;
	logic [TAB_W-1:0]      tab_diff;
	logic [TAB_W+15:0]     tab_mul;

	always_comb begin
		tab_pos  = P_W'(e_q[15:0]) * P_W'(EXP_TABLE_DEPTH);
		tix      = TIX_W'(tab_pos[P_W-1:16]);
		tab_w    = tab_pos[15:0];
		tab_lo   = EXP_TAB[tix];
		tab_hi   = EXP_TAB[tix + TIX_W'(1)];
		tab_diff = tab_hi - tab_lo;
		tab_mul  = (TAB_W+16)'(tab_diff) * (TAB_W+16)'(tab_w);
	end

	// Scale by the integer part of the exponent and add with saturation.
	logic [TAB_W-1:0]       mant;
	logic [SH_W-1:0]        sh;
	logic [SH_W-1:0]        rs;
	logic                   sh_big;
	logic                   rs_big;
	logic                   inc_sat;
	logic [SHL_W-1:0]       inc;
	logic [SHL_W:0]         acc_sum;
	logic [ACCUM_WIDTH-1:0] acc_new;

	always_comb begin
		mant    = tbase_q + tint_q;
		sh      = {e_q[EXPN_W-1], e_q[EXPN_W-1:16]} - SH_W'(8);
		rs      = -sh;
		sh_big  = sh >= SH_W'(ACCUM_WIDTH);
		rs_big  = rs >= SH_W'(PROD_W);
		inc_sat = !sh[SH_W-1] && sh_big && (prod_q != '0);
		if (sh[SH_W-1]) begin
			inc = rs_big ? '0 : SHL_W'(prod_q >> rs[SHR_W-1:0]);
		end else begin
			inc = sh_big ? '0 : (SHL_W'(prod_q) << sh[SHA_W-1:0]);
		end
		acc_sum = (SHL_W+1)'(acc_q) + (SHL_W+1)'(inc);
		acc_new = (inc_sat || acc_sum > (SHL_W+1)'(ACC_MAX)) ? ACC_MAX
			: acc_sum[ACCUM_WIDTH-1:0];
	end

	// TWA: criterion plus rounded q * lg * log10(2), saturated to 16 bits.
	logic [T2_W:0]   tr_sum;
	logic [T2_W-33:0] tr;
	logic [LVL_W+5:0] twa_sum;
	logic [LVL_W-1:0] twa_sat;

	always_comb begin
		tr_sum  = {t2_q[T2_W-1], t2_q} + (T2_W+1)'(64'd1 << 32);
		tr      = tr_sum[T2_W:33];
		twa_sum = (LVL_W+6)'({{6{crit_q[LVL_W-1]}}, crit_q}) + {tr[T2_W-33], tr};
		if (!twa_sum[LVL_W+5] && (twa_sum[LVL_W+4:LVL_W-1] != '0)) begin
			twa_sat = {1'b0, {(LVL_W-1){1'b1}}};
		end else if (twa_sum[LVL_W+5] && (twa_sum[LVL_W+4:LVL_W-1] != '1)) begin
			twa_sat = {1'b1, {(LVL_W-1){1'b0}}};
		end else begin
			twa_sat = twa_sum[LVL_W-1:0];
		end
	end

	assign log_start = (state_q == S_LOG_LD);

	// Item sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!meas.mode && meas.duration_ms != '0 && !below) begin
							state_q <= S_EXP_LD;
						end else begin
							state_q <= S_DOSE_LD;
						end
					end
				end
				S_EXP_LD:   state_q <= S_EXP_DIV;
				S_EXP_DIV:  if (div_stat.done) state_q <= S_EXP_TAB;
				S_EXP_TAB:  state_q <= S_EXP_PROD;
				S_EXP_PROD: state_q <= S_EXP_ADD;
				S_EXP_ADD:  state_q <= S_DOSE_LD;
				S_DOSE_LD:  state_q <= S_DOSE_DIV;
				S_DOSE_DIV: if (div_stat.done) state_q <= S_PROJ_LD;
				S_PROJ_LD:  state_q <= S_PROJ_DIV;
				S_PROJ_DIV: begin
					if (div_stat.done) begin
						state_q <= (dose_q != '0) ? S_LOG_LD : S_FIN;
					end
				end
				S_LOG_LD:   state_q <= S_LOG_RUN;
				S_LOG_RUN:  if (log_done) state_q <= S_TWA_M1;
				S_TWA_M1:   state_q <= S_TWA_M2;
				S_TWA_M2:   state_q <= S_TWA_SUM;
				S_TWA_SUM:  state_q <= S_FIN;
				S_FIN:      if (fin_go) state_q <= S_IDLE;
			endcase
		end
	end

	// Dose and time stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			tb_q  <= '0;
			tt_q  <= '0;
		end else if (accept) begin
			if (meas.mode) begin
				acc_q <= '0;
				tb_q  <= '0;
				tt_q  <= '0;
			end else if (meas.duration_ms != '0) begin
				tt_q <= tt_add;
				if (below) tb_q <= tb_add;
			end
		end else if (state_q == S_EXP_ADD) begin
			acc_q <= acc_new;
		end
	end

	// Working registers along the sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= d_new;
			dur_q <= meas.duration_ms;
		end
		if (state_q == S_EXP_DIV && div_stat.done) begin
			e_q <= d_q[DIFF_W-1] ? (-e_mag) : e_mag;
		end
		if (state_q == S_EXP_TAB) begin
			tbase_q <= tab_lo;
			tint_q  <= tab_mul[TAB_W+15:16];
		end
		if (state_q == S_EXP_PROD) begin
			prod_q <= PROD_W'(dur_q) * PROD_W'(mant);
		end
		if (state_q == S_DOSE_DIV && div_stat.done) begin
			dose_q <= (ct_q == '0) ? '0 : sat_pct(div_quo);
		end
		if (state_q == S_PROJ_DIV && div_stat.done) begin
			proj_q <= (tt_q != '0 && ct_q != '0) ? sat_pct(div_quo) : '0;
			twa_q  <= '0;
		end
		if (state_q == S_LOG_RUN && log_done) begin
			lg_q <= $signed({1'b0, log_val}) - $signed({1'b0, LOG2_25600});
		end
		if (state_q == S_TWA_M1) begin
			t1_q <= T1_W'(lg_q) * T1_W'($signed({1'b0, q_q}));
		end
		if (state_q == S_TWA_M2) begin
			t2_q <= T2_W'(t1_q) * T2_W'($signed({1'b0, LOG10_2_Q16}));
		end
		if (state_q == S_TWA_SUM) begin
			twa_q <= twa_sat;
		end
	end

	// Output register: holds a report until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (fin_go) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rpt_dose_q <= dose_q;
			rpt_proj_q <= proj_q;
			rpt_pv_q   <= tt_q != '0;
			rpt_twa_q  <= twa_q;
			rpt_tv_q   <= dose_q != '0;
			rpt_tb_q   <= tb_q;
			rpt_tt_q   <= tt_q;
		end
	end

	assign report.valid             = rpt_valid_q;
	assign report.dose_percent      = rpt_dose_q;
	assign report.projected_percent = rpt_proj_q;
	assign report.projected_valid   = rpt_pv_q;
	assign report.twa_level         = rpt_twa_q;
	assign report.twa_valid         = rpt_tv_q;
	assign report.below_time_ms     = rpt_tb_q;
	assign report.total_time_ms     = rpt_tt_q;

	// Checks on store consistency, report flags and the handoff to the output register.
	`NDA_ASSERT_NEXT(a_clear_empties, clk, arst_n, accept && meas.mode, acc_q == '0 && tb_q == '0 && tt_q == '0, "clear word left accumulated state")
	`NDA_ASSERT_SAME(a_below_le_total, clk, arst_n, 1'b1, tb_q <= tt_q, "below-threshold time exceeds total time")
	`NDA_ASSERT_SAME(a_twa_flag, clk, arst_n, report.valid, report.twa_valid == (report.dose_percent != '0), "twa_valid disagrees with dose percent")
	`NDA_ASSERT_SAME(a_proj_flag, clk, arst_n, report.valid && !report.projected_valid, report.projected_percent == '0 && report.total_time_ms == '0, "projection reported without total time")
	`NDA_ASSERT_NEXT(a_fin_handoff, clk, arst_n, fin_go, rpt_valid_q && state_q == S_IDLE, "finished report not handed to the output register")

endmodule

@@ tb/sv/noise_dose_accumulator_core_tb.sv @@
// Self-checking testbench for the noise dose accumulator core, with its own predictor.
module noise_dose_accumulator_core_tb;
	import nda_pkg::*;

	// One dose report as the block presents it.
	typedef struct {
		logic [31:0]        dose;
		logic [31:0]        proj;
		logic               proj_ok;
		logic signed [15:0] twa;
		logic               twa_ok;
		logic [39:0]        below;
		logic [39:0]        total;
	} dose_report_t;

	// Predicts each report from accepted words and compares it with what comes out.
	class dose_scoreboard;
		longint unsigned exp2_tab [0:EXP_TABLE_DEPTH];
		int              thr_lvl;
		int              crit_lvl;
		longint          exch_q;
		longint unsigned crit_ms;
		longint unsigned dose_acc;
		longint unsigned below_ms;
		longint unsigned total_ms;
		dose_report_t    pending_reports [$];
		int              errors;
		int              reports_seen;

		function new();
			longint unsigned c [1:16];
			longint unsigned x;
			longint unsigned v;
			c[1] = isqrt(64'd1 << 61);
			for (int i = 2; i <= 16; i++) c[i] = isqrt(c[i-1] << 30);
			for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
				x = (longint'(k) << 16) / EXP_TABLE_DEPTH;
				v = 64'd1 << 30;
				for (int i = 1; i <= 16; i++)
					if ((x >> (16 - i)) & 1) v = (v * c[i] + (64'd1 << 29)) >> 30;
				exp2_tab[k] = (v + (64'd1 << 13)) >> 14;
			end
			exp2_tab[EXP_TABLE_DEPTH] = 131072;
			thr_lvl = 10240;
			crit_lvl = 10880;
			exch_q = 2551;
			crit_ms = 28800000;
			dose_acc = 0;
			below_ms = 0;
			total_ms = 0;
			errors = 0;
			reports_seen = 0;
		endfunction

		function longint unsigned isqrt(longint unsigned v_in);
			longint unsigned v;
			longint unsigned r;
			longint unsigned b;
			v = v_in;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint floor_quot(longint n, longint d);
			if (n >= 0) return n / d;
			return -((-n + d - 1) / d);
		endfunction

		function longint unsigned add_clamped(longint unsigned a, longint unsigned b,
				longint unsigned lim);
			if (a > lim || b > lim - a) return lim;
			return a + b;
		endfunction

		// Dose added by one block: duration times 2^(e/65536) in 1/256 ms.
		function longint unsigned dose_step(longint d, longint unsigned dur);
			longint          q;
			longint          e;
			longint          ip;
			longint          sh;
			longint unsigned f;
			longint unsigned p;
			longint unsigned idx;
			longint unsigned w;
			longint unsigned m;
			longint unsigned prod;
			longint unsigned lim;
			lim = 64'(ACC_MAX);
			q = (exch_q != 0) ? exch_q : 1;
			e = floor_quot(2 * d * 217706, q);
			ip = floor_quot(e, 65536);
			f = longint'(e - ip * 65536);
			p = f * EXP_TABLE_DEPTH;
			idx = p >> 16;
			w = p & 64'hFFFF;
			m = exp2_tab[idx] + (((exp2_tab[idx+1] - exp2_tab[idx]) * w) >> 16);
			prod = dur * m;
			sh = ip - 8;
			if (sh >= 0) begin
				if (prod == 0) return 0;
				if (sh >= 64 || prod > (lim >> sh)) return lim;
				return prod << sh;
			end
			if (-sh >= 64) return 0;
			return prod >> (-sh);
		endfunction

		function longint unsigned percent_of(longint unsigned num, longint unsigned den);
			longint unsigned qt;
			longint unsigned rm;
			longint unsigned v;
			qt = num / den;
			rm = num % den;
			if (qt > 42949672) return 32'hFFFF_FFFF;
			v = 100 * qt + (100 * rm) / den;
			return (v > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : v;
		endfunction

		function longint log2_fix(longint unsigned x);
			int              n;
			longint unsigned y;
			longint          r;
			n = 63;
			while (n > 0 && !((x >> n) & 1)) n--;
			y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
			r = longint'(n) * 65536;
			for (int i = 15; i >= 0; i--) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r = r + (longint'(1) << i);
				end
			end
			return r;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_THRESHOLD: thr_lvl = int'($signed(val[15:0]));
				REG_CRITERION: crit_lvl = int'($signed(val[15:0]));
				REG_EXCHANGE:  exch_q = longint'(val[13:0]);
				REG_CRIT_TIME: crit_ms = longint'(val[24:0]);
				default: ;
			endcase
		endfunction

		// Applies one accepted word and queues the report it must produce.
		function void note_block(logic mode, logic signed [15:0] lvl, logic [15:0] dur);
			dose_report_t    r;
			longint unsigned dose;
			longint unsigned proj;
			longint          lg;
			longint          t;
			longint          v;
			if (mode) begin
				dose_acc = 0;
				below_ms = 0;
				total_ms = 0;
			end else if (dur != 0) begin
				total_ms = add_clamped(total_ms, dur, 64'(TIME_MAX));
				if (int'(lvl) < thr_lvl)
					below_ms = add_clamped(below_ms, dur, 64'(TIME_MAX));
				else
					dose_acc = add_clamped(dose_acc,
						dose_step(longint'(lvl) - crit_lvl, dur), 64'(ACC_MAX));
			end
			dose = (crit_ms != 0) ? percent_of(dose_acc, crit_ms) : 0;
			proj = (total_ms != 0 && crit_ms != 0) ? percent_of(dose_acc, total_ms) : 0;
			r.dose = dose[31:0];
			r.proj = proj[31:0];
			r.proj_ok = (total_ms != 0);
			r.twa_ok = (dose != 0);
			r.twa = 0;
			if (dose != 0) begin
				lg = log2_fix(dose) - log2_fix(25600);
				t = exch_q * lg * 19728;
				v = crit_lvl + ((t + (longint'(1) << 32)) >>> 33);
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				r.twa = v[15:0];
			end
			r.below = below_ms[39:0];
			r.total = total_ms[39:0];
			pending_reports.push_back(r);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_report(dose_report_t got);
			dose_report_t want;
			reports_seen++;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: report word with no pending expectation, dose %0h",
					$time, got.dose);
				return;
			end
			want = pending_reports.pop_front();
			compare_field("dose_percent", want.dose, got.dose);
			compare_field("projected_percent", want.proj, got.proj);
			compare_field("projected_valid", want.proj_ok, got.proj_ok);
			compare_field("twa_level", 64'(want.twa[15:0]), 64'(got.twa[15:0]));
			compare_field("twa_valid", want.twa_ok, got.twa_ok);
			compare_field("below_time_ms", want.below, got.below);
			compare_field("total_time_ms", want.total, got.total);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	nda_meas_if   meas_ch();
	nda_report_if report_ch();

	dose_scoreboard dose_sb;
	bit             no_idle;
	int             hold_request;
	int             blocks_sent;
	int             clears_sent;

	noise_dose_accumulator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.meas    (meas_ch),
		.report  (report_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Accepted words on both channels, sampled at the rising edge.
	always @(posedge clk) begin
		dose_report_t got;
		if (arst_n) begin
			if (meas_ch.valid && meas_ch.ready)
				dose_sb.note_block(meas_ch.mode, meas_ch.level, meas_ch.duration_ms);
			if (report_ch.valid && report_ch.ready) begin
				got.dose = report_ch.dose_percent;
				got.proj = report_ch.projected_percent;
				got.proj_ok = report_ch.projected_valid;
				got.twa = report_ch.twa_level;
				got.twa_ok = report_ch.twa_valid;
				got.below = report_ch.below_time_ms;
				got.total = report_ch.total_time_ms;
				dose_sb.check_report(got);
			end
		end
	end

	// Report receiver: random stalls, plus a long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_ch.ready = 1'b0;
			end else begin
				report_ch.ready = no_idle || ($urandom_range(99) >= 18);
			end
		end
	end

	// Register write over the configuration port; the scoreboard follows it.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		dose_sb.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_config(logic [15:0] thr, logic [15:0] crit, logic [13:0] q,
			logic [24:0] ct);
		write_reg(REG_THRESHOLD, 32'(thr));
		write_reg(REG_CRITERION, 32'(crit));
		write_reg(REG_EXCHANGE, 32'(q));
		write_reg(REG_CRIT_TIME, 32'(ct));
	endtask

	// Offers one word, with random idle cycles ahead of it, until it is taken.
	task automatic send_block(logic mode, logic [15:0] lvl, logic [15:0] dur);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 18) begin
			meas_ch.valid = 1'b0;
			@(negedge clk);
		end
		meas_ch.valid = 1'b1;
		meas_ch.mode = mode;
		meas_ch.level = lvl;
		meas_ch.duration_ms = dur;
		@(posedge clk);
		while (!meas_ch.ready) @(posedge clk);
		blocks_sent++;
		if (mode) clears_sent++;
	endtask

	// Drops valid and waits until every pending report has come back.
	task automatic drain_reports();
		@(negedge clk);
		meas_ch.valid = 1'b0;
		while (dose_sb.pending_reports.size() != 0) @(posedge clk);
	endtask

	// Random words: mostly levels near the criterion, some clears, zero and full-range fields.
	task automatic random_blocks(int count, logic signed [15:0] crit);
		int          r;
		int          lv;
		logic [15:0] dur;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if ($urandom_range(99) < 70) lv = int'(crit) + $urandom_range(4000) - 2000;
			else lv = $urandom_range(65535) - 32768;
			if (lv > 32767) lv = 32767;
			if (lv < -32768) lv = -32768;
			case ($urandom_range(4))
				0: dur = 16'($urandom_range(100));
				1, 2: dur = 16'($urandom_range(65535, 1));
				default: dur = 16'($urandom);
			endcase
			if (r < 3) send_block(1'b1, 16'($urandom), 16'($urandom));
			else if (r < 8) send_block(1'b0, 16'(lv), 16'd0);
			else send_block(1'b0, 16'(lv), dur);
		end
	endtask

	// Main sequence.
	initial begin
		dose_sb = new();
		no_idle = 1'b0;
		hold_request = 0;
		blocks_sent = 0;
		clears_sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		meas_ch.valid = 1'b0;
		meas_ch.mode = 1'b0;
		meas_ch.level = '0;
		meas_ch.duration_ms = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset settings.
		send_block(1'b0, 16'sd10880, 16'd1000);
		send_block(1'b0, 16'sd10239, 16'd500);
		send_block(1'b0, 16'sd10240, 16'd500);
		send_block(1'b0, 16'sd12000, 16'd0);
		send_block(1'b0, 16'sh7FFF, 16'hFFFF);
		send_block(1'b0, 16'sh7FFF, 16'hFFFF);
		send_block(1'b0, 16'sh8000, 16'hFFFF);
		send_block(1'b1, 16'sh7FFF, 16'hFFFF);
		send_block(1'b1, 16'sd0, 16'd0);
		send_block(1'b0, 16'sd11264, 16'd1);
		drain_reports();

		// Lowest levels and zero divisor, first with zero criterion time, then with a zero criterion.
		set_config(16'h8000, 16'h8000, 14'd0, 25'd0);
		send_block(1'b0, 16'sh8000, 16'hFFFF);
		send_block(1'b0, 16'sh7FFF, 16'h5555);
		send_block(1'b0, 16'sh0000, 16'hAAAA);
		send_block(1'b1, 16'sd0, 16'd0);
		drain_reports();
		set_config(16'h8000, 16'h0000, 14'd0, 25'd3600000);
		send_block(1'b0, 16'sd256, 16'd4000);
		send_block(1'b0, 16'shFF00, 16'd4000);
		drain_reports();

		// Highest levels, divisor and criterion time.
		set_config(16'h7FFF, 16'h7FFF, 14'h3FFF, 25'h1FF_FFFF);
		send_block(1'b0, 16'sh7FFF, 16'hFFFF);
		send_block(1'b0, 16'sh7FFE, 16'hFFFF);
		send_block(1'b0, 16'sh8000, 16'd1);
		send_block(1'b1, 16'sh7FFF, 16'd7);
		drain_reports();

		// Random phases, each under its own settings; the first one fills the block
		// with a long receiver hold-off, the last one runs with no idling at all.
		for (int ph = 0; ph < 8; ph++) begin
			logic [15:0] crit;
			crit = 16'($urandom_range(14000, 7000));
			if (ph == 0) crit = 16'sd10880;
			if (ph == 0)
				set_config(16'sd10240, crit, 14'd2551, 25'd28800000);
			else if (ph == 1)
				set_config(16'($urandom), crit, 14'd0, 25'($urandom_range(100000)));
			else if (ph == 2)
				set_config(crit - 16'd640, crit, 14'd2560, 25'($urandom));
			else
				set_config(crit - 16'($urandom_range(2000)), crit,
					14'($urandom_range(16383)), 25'($urandom_range(33554431)));
			no_idle = (ph == 7);
			if (ph == 0) begin
				random_blocks(20, crit);
				hold_request = 3000;
			end
			random_blocks(220, crit);
			drain_reports();
			no_idle = 1'b0;
		end

		repeat (300) @(posedge clk);
		$display("Sent %0d words (%0d clears), checked %0d reports under 12 register settings.",
			blocks_sent, clears_sent, dose_sb.reports_seen);
		if (dose_sb.errors == 0 && dose_sb.pending_reports.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d reports still pending", dose_sb.pending_reports.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Timeout guard.
	initial begin
		#200000000;
		$display("Timeout waiting for the block");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/nda_pkg.sv
hdl/nda_meas_if.sv
hdl/nda_report_if.sv
hdl/nda_div.sv
hdl/nda_log.sv
hdl/noise_dose_accumulator_core.sv
tb/sv/noise_dose_accumulator_core_tb.sv
